// ===== sv/eegpp_pkg.sv =====
package eegpp_pkg;

   localparam int unsigned BYTE_W              = 8;
   localparam int unsigned RAW_W               = 16;
   localparam int unsigned SKIP_W              = 5;
   localparam int unsigned MAX_PAYLOAD_DEFAULT = 169;

   localparam logic [BYTE_W-1:0] SYNC_BYTE       = 8'd170;
   localparam logic [BYTE_W-1:0] QUALITY_DEFAULT = 8'd200;
   localparam logic [SKIP_W-1:0] SKIP_COUNT      = 5'd25;

   localparam logic [BYTE_W-1:0] CODE_QUALITY    = 8'h02;
   localparam logic [BYTE_W-1:0] CODE_ATTENTION  = 8'h04;
   localparam logic [BYTE_W-1:0] CODE_MEDITATION = 8'h05;
   localparam logic [BYTE_W-1:0] CODE_RAW        = 8'h80;
   localparam logic [BYTE_W-1:0] CODE_SKIP       = 8'h83;

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_sample;
      logic [BYTE_W-1:0]       meditation_level;
      logic [BYTE_W-1:0]       attention_level;
      logic [BYTE_W-1:0]       signal_quality;
   } rsp_data_type;

   localparam int unsigned RSP_DATA_W = $bits(rsp_data_type);

endpackage

// ===== sv/eeg_headset_packet_parser.sv =====
// channel | direction | tdata (lowest bit up)                         | tuser
// req     | in        | rx_byte[7:0]                                  | -
// rsp     | out       | signal_quality, attention_level,              | raw_updated
//         |           | meditation_level, raw_sample (signed 16 bits) |
//
// One byte per cycle while the result register is free or being taken; a byte waits in the input register
// and the frame decode runs between that register and the result register.
// A good checksum byte loads the result register as it leaves the input register,
// so the result passes from the input register through the decode into the result register.
// Reset is synchronous: the parser hunts for the first sync byte, held raw is zero.
// A result not taken stalls the input register, which then drops req_tready.
module eeg_headset_packet_parser #(
   parameter int unsigned MAX_PAYLOAD = eegpp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [eegpp_pkg::BYTE_W-1:0]          req_tdata,   // rx_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [eegpp_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // quality, attention,
                                                             // meditation, raw_sample
   output logic                                  rsp_tuser    // raw_updated
);
   import eegpp_pkg::*;

   typedef enum logic [2:0] {
      FR_HUNT1, FR_HUNT2, FR_LEN, FR_PAYLOAD, FR_CHECK
   } frame_type;

   typedef enum logic [2:0] {
      FP_CODE, FP_QUAL, FP_ATT, FP_MED, FP_RLEN, FP_RHI, FP_RLO, FP_SKIP
   } field_type;

   localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff, in_byte_in;
   logic               advance;

   frame_type          frame_ff, frame_in;
   field_type          field_ff, field_in;
   logic [BYTE_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0]  seen_ff, seen_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [SKIP_W-1:0]  skip_ff, skip_in;
   logic [SKIP_W-1:0]  skip_dec;
   logic [BYTE_W-1:0]  quality_ff, quality_in;
   logic [BYTE_W-1:0]  attention_ff, attention_in;
   logic [BYTE_W-1:0]  meditation_ff, meditation_in;
   logic [RAW_W-1:0]   raw_ff, raw_in;
   logic               raw_flag_ff, raw_flag_in;
   logic [BYTE_W-1:0]  raw_high_ff, raw_high_in;
   logic [RAW_W-1:0]   held_raw_ff, held_raw_in;

   logic               out_valid_ff, out_valid_in;
   rsp_data_type       out_data_ff, out_data_in;
   logic               out_flag_ff, out_flag_in;

   logic [BYTE_W-1:0]  b;
   logic [BYTE_W-1:0]  seen_next;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_flag_ff;

   assign b         = in_byte_ff;
   assign seen_next = seen_ff + BYTE_W'(1);
   assign skip_dec  = (skip_ff != '0) ? skip_ff - SKIP_W'(1) : skip_ff;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      frame_in      = frame_ff;
      field_in      = field_ff;
      length_in     = length_ff;
      seen_in       = seen_ff;
      sum_in        = sum_ff;
      skip_in       = skip_ff;
      quality_in    = quality_ff;
      attention_in  = attention_ff;
      meditation_in = meditation_ff;
      raw_in        = raw_ff;
      raw_flag_in   = raw_flag_ff;
      raw_high_in   = raw_high_ff;
      held_raw_in   = held_raw_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_data_in   = out_data_ff;
      out_flag_in   = out_flag_ff;

      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end

      if (advance) begin
         unique case (frame_ff)
            FR_HUNT2: begin
               frame_in = (b == SYNC_BYTE) ? FR_LEN : FR_HUNT1;
            end
            FR_LEN: begin
               if (b > MAX_LEN) begin
                  frame_in = FR_HUNT1;
               end else begin
                  length_in     = b;
                  seen_in       = '0;
                  sum_in        = '0;
                  field_in      = FP_CODE;
                  skip_in       = '0;
                  quality_in    = QUALITY_DEFAULT;
                  attention_in  = '0;
                  meditation_in = '0;
                  raw_in        = '0;
                  raw_flag_in   = 1'b0;
                  raw_high_in   = '0;
                  frame_in      = (b == '0) ? FR_CHECK : FR_PAYLOAD;
               end
            end
            FR_PAYLOAD: begin
               sum_in  = sum_ff + b;
               seen_in = seen_next;
               if (seen_next >= length_ff) begin
                  frame_in = FR_CHECK;
               end
               unique case (field_ff)
                  FP_QUAL: begin
                     quality_in = b;
                     field_in   = FP_CODE;
                  end
                  FP_ATT: begin
                     attention_in = b;
                     field_in     = FP_CODE;
                  end
                  FP_MED: begin
                     meditation_in = b;
                     field_in      = FP_CODE;
                  end
                  FP_RLEN: begin
                     field_in = FP_RHI;
                  end
                  FP_RHI: begin
                     raw_high_in = b;
                     field_in    = FP_RLO;
                  end
                  FP_RLO: begin
                     raw_in      = {raw_high_ff, b};
                     raw_flag_in = 1'b1;
                     field_in    = FP_CODE;
                  end
                  FP_SKIP: begin
                     skip_in = skip_dec;
                     if (skip_dec == '0) begin
                        field_in = FP_CODE;
                     end
                  end
                  default: begin
                     unique case (b)
                        CODE_QUALITY:    field_in = FP_QUAL;
                        CODE_ATTENTION:  field_in = FP_ATT;
                        CODE_MEDITATION: field_in = FP_MED;
                        CODE_RAW:        field_in = FP_RLEN;
                        CODE_SKIP: begin
                           skip_in  = SKIP_COUNT;
                           field_in = FP_SKIP;
                        end
                        default:         field_in = FP_CODE;
                     endcase
                  end
               endcase
            end
            FR_CHECK: begin
               if (b == ~sum_ff) begin
                  if (raw_flag_ff) begin
                     held_raw_in = raw_ff;
                  end
                  out_valid_in                 = 1'b1;
                  out_data_in.signal_quality   = quality_ff;
                  out_data_in.attention_level  = attention_ff;
                  out_data_in.meditation_level = meditation_ff;
                  out_data_in.raw_sample       = raw_flag_ff ? raw_ff : held_raw_ff;
                  out_flag_in                  = raw_flag_ff;
               end
               frame_in = FR_HUNT1;
            end
            default: begin
               frame_in = (b == SYNC_BYTE) ? FR_HUNT2 : FR_HUNT1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         frame_ff     <= FR_HUNT1;
         field_ff     <= FP_CODE;
         length_ff    <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         skip_ff      <= '0;
         held_raw_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         frame_ff     <= frame_in;
         field_ff     <= field_in;
         length_ff    <= length_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         skip_ff      <= skip_in;
         held_raw_ff  <= held_raw_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff    <= in_byte_in;
      quality_ff    <= quality_in;
      attention_ff  <= attention_in;
      meditation_ff <= meditation_in;
      raw_ff        <= raw_in;
      raw_flag_ff   <= raw_flag_in;
      raw_high_ff   <= raw_high_in;
      out_data_ff   <= out_data_in;
      out_flag_ff   <= out_flag_in;
   end

   a_result_after_check: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(frame_ff == FR_CHECK))
      else $error("result raised outside checksum phase");

   a_skip_matches_phase: assert property (@(posedge clock) disable iff (reset)
      (field_ff == FP_SKIP) == (skip_ff != '0))
      else $error("skip count out of step with field phase");

   a_input_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input byte lost");

endmodule
